### hdl/sws_pkg.sv
// shared types and constants of the stop-and-wait sender
package sws_pkg;

  localparam int unsigned CmdW      = 2;
  localparam int unsigned KindW     = 2;
  localparam int unsigned RxSeqW    = 8;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned AttemptW  = 4;
  localparam int unsigned TicksW    = 16;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 16;

  localparam logic [AttemptW-1:0] RetryLimitRst   = 4'd3;
  localparam logic [TicksW-1:0]   TimeoutTicksRst = 16'd3000;

  typedef enum logic [CmdW-1:0] {
    CMD_START = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [KindW-1:0] {
    KIND_HELLO = 2'd0,
    KIND_WRQ   = 2'd1,
    KIND_DATA  = 2'd2,
    KIND_FIN   = 2'd3
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    ST_TRANSMIT  = 3'd0,
    ST_WAITING   = 3'd1,
    ST_ACKED     = 3'd2,
    ST_ACKED_MSG = 3'd3,
    ST_FAILED    = 3'd4,
    ST_REJECTED  = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_RETRY_LIMIT   = 2'd0,
    CFG_TIMEOUT_TICKS = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [CmdW-1:0]   command;
    logic [KindW-1:0]  frame_kind;
    logic              rx_is_ack;
    logic [RxSeqW-1:0] rx_seq;
    logic              rx_has_text;
  } item_t;

  typedef struct packed {
    status_e             status;
    logic                tx_seq;
    logic [AttemptW-1:0] attempt_count;
  } result_t;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

endpackage

### hdl/stop_and_wait_sender.sv
// top level of the stop-and-wait sender
// each transaction is held in the input register, and its result is then captured in the result register
// throughput: one transaction per cycle while the output is not stalled, set by the per-transaction state update
// an output stall blocks the input once the input and result registers are both full
// reset: asynchronous active low, idle with retry limit 3 and timeout 3000 ticks
module stop_and_wait_sender (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [sws_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [sws_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sws_pkg::CmdW-1:0]       command_i,
  input  logic [sws_pkg::KindW-1:0]      frame_kind_i,
  input  logic                           rx_is_ack_i,
  input  logic [sws_pkg::RxSeqW-1:0]     rx_seq_i,
  input  logic                           rx_has_text_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [sws_pkg::StatusW-1:0]    status_o,
  output logic                           tx_seq_o,
  output logic [sws_pkg::AttemptW-1:0]   attempt_count_o
);

  sws_pkg::item_t   in_item, stage_item;
  sws_pkg::result_t eng_result, out_result;
  sws_pkg::cfg_wr_t cfg_wr;
  logic             stage_valid;
  logic             out_free;
  logic             adv;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  assign in_item.command     = command_i;
  assign in_item.frame_kind  = frame_kind_i;
  assign in_item.rx_is_ack   = rx_is_ack_i;
  assign in_item.rx_seq      = rx_seq_i;
  assign in_item.rx_has_text = rx_has_text_i;

  assign adv = stage_valid && out_free;

  sws_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .adv_i      (adv),
    .valid_o    (stage_valid),
    .item_o     (stage_item)
  );

  sws_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_wr),
    .adv_i    (adv),
    .item_i   (stage_item),
    .result_o (eng_result)
  );

  sws_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (adv),
    .result_i    (eng_result),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .free_o      (out_free),
    .result_o    (out_result)
  );

  assign status_o        = out_result.status;
  assign tx_seq_o        = out_result.tx_seq;
  assign attempt_count_o = out_result.attempt_count;

endmodule

### hdl/sws_in_reg.sv
// input register holding one accepted transaction
module sws_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  sws_pkg::item_t item_i,
  input  logic           adv_i,
  output logic           valid_o,
  output sws_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  sws_pkg::item_t item_q, item_d;
  logic           load;

  assign in_ready_o = !valid_q || adv_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (load) begin
      valid_d = 1'b1;
      item_d  = item_i;
    end else if (adv_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

### hdl/sws_engine.sv
// protocol state, configuration registers and per-event update logic
module sws_engine (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sws_pkg::cfg_wr_t cfg_i,
  input  logic             adv_i,
  input  sws_pkg::item_t   item_i,
  output sws_pkg::result_t result_o
);

  logic [sws_pkg::AttemptW-1:0] retry_limit_q;
  logic [sws_pkg::TicksW-1:0]   timeout_ticks_q;

  logic                         busy_q, busy_d;
  logic [sws_pkg::AttemptW-1:0] attempts_q, attempts_d;
  logic [sws_pkg::TicksW-1:0]   ticks_q, ticks_d;
  logic                         cur_seq_q, cur_seq_d;
  logic                         cur_data_q, cur_data_d;
  logic                         data_seq_q, data_seq_d;
  logic                         last_seq_q, last_seq_d;

  logic [sws_pkg::AttemptW-1:0] eff_limit;
  logic [sws_pkg::TicksW-1:0]   eff_timeout;
  logic [sws_pkg::AttemptW-1:0] attempts_inc;
  logic                         seq_match;
  sws_pkg::status_e             status;
  sws_pkg::cmd_e                cmd;
  sws_pkg::kind_e               kind;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      retry_limit_q   <= sws_pkg::RetryLimitRst;
      timeout_ticks_q <= sws_pkg::TimeoutTicksRst;
    end else if (cfg_i.valid) begin
      unique case (sws_pkg::cfg_idx_e'(cfg_i.index))
        sws_pkg::CFG_RETRY_LIMIT: begin
          retry_limit_q <= cfg_i.data[sws_pkg::AttemptW-1:0];
        end
        sws_pkg::CFG_TIMEOUT_TICKS: begin
          timeout_ticks_q <= cfg_i.data[sws_pkg::TicksW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // zero acts as one
  assign eff_limit    = (retry_limit_q == '0) ? sws_pkg::AttemptW'(1) : retry_limit_q;
  assign eff_timeout  = (timeout_ticks_q == '0) ? sws_pkg::TicksW'(1) : timeout_ticks_q;
  assign attempts_inc = attempts_q + sws_pkg::AttemptW'(1);
  assign seq_match    = (item_i.rx_seq == {{(sws_pkg::RxSeqW-1){1'b0}}, cur_seq_q});
  assign cmd          = sws_pkg::cmd_e'(item_i.command);
  assign kind         = sws_pkg::kind_e'(item_i.frame_kind);

  always_comb begin
    busy_d     = busy_q;
    attempts_d = attempts_q;
    ticks_d    = ticks_q;
    cur_seq_d  = cur_seq_q;
    cur_data_d = cur_data_q;
    data_seq_d = data_seq_q;
    last_seq_d = last_seq_q;
    status     = sws_pkg::ST_WAITING;
    unique case (cmd)
      sws_pkg::CMD_START: begin
        if (busy_q) begin
          status = sws_pkg::ST_REJECTED;
        end else begin
          case (kind)
            sws_pkg::KIND_HELLO: cur_seq_d = 1'b0;
            sws_pkg::KIND_WRQ:   cur_seq_d = 1'b1;
            sws_pkg::KIND_DATA:  cur_seq_d = data_seq_q;
            default:             cur_seq_d = !last_seq_q;
          endcase
          cur_data_d = (kind == sws_pkg::KIND_DATA);
          busy_d     = 1'b1;
          attempts_d = '0;
          ticks_d    = eff_timeout;
          status     = sws_pkg::ST_TRANSMIT;
        end
      end
      sws_pkg::CMD_FRAME: begin
        if (busy_q && item_i.rx_is_ack && seq_match) begin
          busy_d  = 1'b0;
          ticks_d = '0;
          if (item_i.rx_has_text) begin
            status = sws_pkg::ST_ACKED_MSG;
          end else begin
            status = sws_pkg::ST_ACKED;
            if (cur_data_q) begin
              last_seq_d = cur_seq_q;
              data_seq_d = !data_seq_q;
            end
          end
        end
      end
      sws_pkg::CMD_TICK: begin
        if (busy_q) begin
          if (ticks_q > sws_pkg::TicksW'(1)) begin
            ticks_d = ticks_q - sws_pkg::TicksW'(1);
          end else begin
            attempts_d = attempts_inc;
            if (attempts_inc >= eff_limit) begin
              busy_d  = 1'b0;
              ticks_d = '0;
              status  = sws_pkg::ST_FAILED;
            end else begin
              ticks_d = eff_timeout;
              status  = sws_pkg::ST_TRANSMIT;
            end
          end
        end
      end
      default: begin
        status = sws_pkg::ST_WAITING;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      attempts_q <= '0;
      ticks_q    <= '0;
      cur_seq_q  <= 1'b0;
      cur_data_q <= 1'b0;
      data_seq_q <= 1'b0;
      last_seq_q <= 1'b0;
    end else if (adv_i) begin
      busy_q     <= busy_d;
      attempts_q <= attempts_d;
      ticks_q    <= ticks_d;
      cur_seq_q  <= cur_seq_d;
      cur_data_q <= cur_data_d;
      data_seq_q <= data_seq_d;
      last_seq_q <= last_seq_d;
    end
  end

  assign result_o.status        = status;
  assign result_o.tx_seq        = cur_seq_d;
  assign result_o.attempt_count = attempts_d;

  a_idle_timer_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ticks_q == '0)
    else $error("timer running while idle");

  a_frame_end_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv_i && busy_q && !busy_d) |->
      (status == sws_pkg::ST_ACKED || status == sws_pkg::ST_ACKED_MSG ||
       status == sws_pkg::ST_FAILED))
    else $error("frame ended without final status");

  a_data_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(data_seq_q) |->
      $past(adv_i && status == sws_pkg::ST_ACKED && cur_data_q))
    else $error("data sequence moved without data ack");

endmodule

### hdl/sws_out_reg.sv
// result register feeding the output channel
module sws_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  sws_pkg::result_t result_i,
  input  logic             out_ready_i,
  output logic             out_valid_o,
  output logic             free_o,
  output sws_pkg::result_t result_o
);

  logic             valid_q, valid_d;
  sws_pkg::result_t result_q;

  assign free_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule
